>>> rtl/rgb_led_rainbow_code_generator_assert.svh
// Assertion helpers shared by the rainbow encoder RTL
`ifndef RGB_LED_RAINBOW_CODE_GENERATOR_ASSERT_SVH
`define RGB_LED_RAINBOW_CODE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define RLRCG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RLRCG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rlrcg_pkg.sv
// ----------------------------------------------------------------------------
// rlrcg_pkg
// Types and constants for the WS2812 rainbow pixel encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rlrcg_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_PIXEL_COUNT = 2'd0;
    localparam logic [1:0] REG_CODE_ZERO   = 2'd1;
    localparam logic [1:0] REG_CODE_ONE    = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int KIND_COLOUR  = 0;
    localparam int KIND_RAINBOW = 1;

    // divider geometry: 18-bit dividend (index * 255), 11-bit divisor
    localparam int DVD_W           = 18;
    localparam int REM_W           = 11;
    localparam int DIV_STAGES      = 6;
    localparam int STEPS_PER_STAGE = 3;

    localparam int           BITS_PER_PIXEL = 24;
    localparam int           CNT_W          = 5;
    localparam logic [CNT_W-1:0] LAST_IDX   = CNT_W'(BITS_PER_PIXEL - 1);

    typedef struct packed {
        logic        kind;
        logic [23:0] color_value;
        logic [9:0]  pixel_index;
        logic [7:0]  phase;
    } t_in_item;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last;
    } t_out_item;

    // item in flight through the divider; quo holds the dividend bits not yet
    // consumed at the top and the quotient bits produced so far at the bottom
    typedef struct packed {
        logic             kind;
        logic [23:0]      aux;
        logic [REM_W-1:0] rem;
        logic [DVD_W-1:0] quo;
    } t_div_item;

endpackage

`default_nettype wire

>>> rtl/rlrcg_div.sv
// ----------------------------------------------------------------------------
// rlrcg_div
// Pipelined restoring divider, three quotient bits per stage, with side data.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb_led_rainbow_code_generator_assert.svh"

module rlrcg_div import rlrcg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_div_item        i_item,
    input  logic [REM_W-1:0] i_divisor,
    output logic             o_valid,
    input  logic             i_ready,
    output t_div_item        o_item
);

    logic [DIV_STAGES-1:0] r_valid;
    t_div_item             r_item [DIV_STAGES];
    t_div_item             n_item [DIV_STAGES];
    logic [DIV_STAGES-1:0] s_ready;

    function automatic t_div_item div_steps(input t_div_item a, input logic [REM_W-1:0] d);
        t_div_item      t;
        logic [REM_W:0] sh;
        logic           qb;
        t = a;
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            sh = {t.rem, t.quo[DVD_W-1]};
            qb = (sh >= {1'b0, d});
            if (qb) begin
                sh = sh - {1'b0, d};
            end
            t.rem = sh[REM_W-1:0];
            t.quo = {t.quo[DVD_W-2:0], qb};
        end
        return t;
    endfunction

    always_comb begin
        n_item[0] = div_steps(i_item, i_divisor);
        for (int i = 1; i < DIV_STAGES; i++) begin
            n_item[i] = div_steps(r_item[i-1], i_divisor);
        end
    end

    // a stage may load when empty or when its contents move on
    always_comb begin
        s_ready[DIV_STAGES-1] = !r_valid[DIV_STAGES-1] || i_ready;
        for (int i = DIV_STAGES - 2; i >= 0; i--) begin
            s_ready[i] = !r_valid[i] || s_ready[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (s_ready[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int i = 1; i < DIV_STAGES; i++) begin
                if (s_ready[i]) begin
                    r_valid[i] <= r_valid[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DIV_STAGES; i++) begin
            if (s_ready[i]) begin
                r_item[i] <= n_item[i];
            end
        end
    end

    assign o_ready = s_ready[0];
    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_item  = r_item[DIV_STAGES-1];

    `RLRCG_ASSERT_NXT(a_div_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_item), "divider output lost or changed under stall")
    `RLRCG_ASSERT_NXT(a_div_enter, i_clk, i_rst_n, i_valid && o_ready, r_valid[0], "accepted transaction missing from first divider stage")
    `RLRCG_ASSERT_IMP(a_div_full, i_clk, i_rst_n, !o_ready, &r_valid, "divider back-pressure with a free stage")

endmodule

`default_nettype wire

>>> rtl/rlrcg_ser.sv
// ----------------------------------------------------------------------------
// rlrcg_ser
// Serialiser: turns one 24-bit GRB word into 24 SPI code bytes, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb_led_rainbow_code_generator_assert.svh"

module rlrcg_ser import rlrcg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [23:0] i_grb,
    input  logic [7:0]  i_code_zero,
    input  logic [7:0]  i_code_one,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    logic             r_valid;
    logic [23:0]      r_grb;
    logic [CNT_W-1:0] r_cnt;
    logic             s_last;
    logic             s_take;

    assign s_last = (r_cnt == LAST_IDX);
    assign s_take = r_valid && i_out_ready;
    // next word loads in the cycle the final byte leaves
    assign o_ready = !r_valid || (i_out_ready && s_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
            r_cnt   <= '0;
        end else if (s_take) begin
            if (s_last) begin
                r_valid <= 1'b0;
            end else begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_grb <= i_grb;
        end else if (s_take) begin
            r_grb <= {r_grb[22:0], 1'b0};
        end
    end

    assign o_out_valid          = r_valid;
    assign o_out_data.code_byte = r_grb[23] ? i_code_one : i_code_zero;
    assign o_out_data.last      = s_last;

    `RLRCG_ASSERT_IMP(a_ser_cnt_range, i_clk, i_rst_n, r_valid, r_cnt <= LAST_IDX, "bit counter past end of pixel")
    `RLRCG_ASSERT_NXT(a_ser_advance, i_clk, i_rst_n, s_take && !s_last, r_valid && (r_cnt == $past(r_cnt) + CNT_W'(1)), "serialiser did not advance by one bit")
    `RLRCG_ASSERT_NXT(a_ser_load, i_clk, i_rst_n, i_valid && o_ready, r_valid && (r_cnt == '0), "new pixel not started at first bit")

endmodule

`default_nettype wire

>>> rtl/rgb_led_rainbow_code_generator.sv
// Takes one pixel request per transaction and returns 24 SPI code bytes, one
// per colour bit in G, R, B order, MSB first, with last set on the 24th byte.
// The output port delivers one byte per cycle while the receiver is ready, so
// the serialiser sets the sustained rate. Requests enter an eight-deep pipeline
// (input register, six divider stages at three quotient bits each, colour-wheel
// register) and a new one is accepted every cycle while the pipeline has room;
// a pixel's first byte leaves the serialiser after the input register, the
// divider stages and the colour-wheel register. The registers feed the
// pipeline directly, so write configuration only while no pixel is in flight.
// ----------------------------------------------------------------------------
// rgb_led_rainbow_code_generator
// WS2812 SPI code-byte encoder with rainbow colour wheel.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_rainbow_code_generator import rlrcg_pkg::*; #(
    parameter int MAX_PIXELS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    // divisor ceiling; pixel_count is 11 bits so larger limits never bind
    localparam int               CLAMP_I = (MAX_PIXELS > 2047) ? 2047 : MAX_PIXELS;
    localparam logic [REM_W-1:0] CLAMP_N = CLAMP_I[REM_W-1:0];

    logic [REM_W-1:0] r_pixel_count;
    logic [7:0]       r_code_zero;
    logic [7:0]       r_code_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= REM_W'(1);
            r_code_zero   <= 8'd192;
            r_code_one    <= 8'd248;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PIXEL_COUNT: r_pixel_count <= i_cfg_data[REM_W-1:0];
                REG_CODE_ZERO:   r_code_zero   <= i_cfg_data[7:0];
                REG_CODE_ONE:    r_code_one    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic [REM_W-1:0] s_divisor;

    always_comb begin
        priority if (r_pixel_count == '0) begin
            s_divisor = REM_W'(1);
        end else if (r_pixel_count > CLAMP_N) begin
            s_divisor = CLAMP_N;
        end else begin
            s_divisor = r_pixel_count;
        end
    end

    // input register: index * 255 as (index << 8) - index
    logic      r_in_valid;
    t_div_item r_in_item;
    t_div_item n_in_item;
    logic      s_div_ready;

    always_comb begin
        n_in_item.kind = i_in_data.kind;
        n_in_item.aux  = i_in_data.kind ? {16'd0, i_in_data.phase} : i_in_data.color_value;
        n_in_item.rem  = '0;
        n_in_item.quo  = {i_in_data.pixel_index, 8'd0} - {8'd0, i_in_data.pixel_index};
    end

    assign o_in_ready = !r_in_valid || s_div_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_item <= n_in_item;
        end
    end

    logic      s_div_valid;
    t_div_item s_div_item;
    logic      s_whl_ready;

    rlrcg_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_in_valid),
        .o_ready   (s_div_ready),
        .i_item    (r_in_item),
        .i_divisor (s_divisor),
        .o_valid   (s_div_valid),
        .i_ready   (s_whl_ready),
        .o_item    (s_div_item)
    );

    // colour wheel: w = 255 - pos, three 85-step segments, steps of 3
    function automatic logic [23:0] wheel_rgb(input logic [7:0] pos);
        logic [7:0] w;
        logic [7:0] v;
        logic [8:0] v3;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        w = ~pos;
        priority if (w < 8'd85) begin
            v = w;
        end else if (w < 8'd170) begin
            v = w - 8'd85;
        end else begin
            v = w - 8'd170;
        end
        v3 = {v, 1'b0} + {1'b0, v};
        priority if (w < 8'd85) begin
            r = 8'd255 - v3[7:0];
            g = 8'd0;
            b = v3[7:0];
        end else if (w < 8'd170) begin
            r = 8'd0;
            g = v3[7:0];
            b = 8'd255 - v3[7:0];
        end else begin
            r = v3[7:0];
            g = 8'd255 - v3[7:0];
            b = 8'd0;
        end
        return {r, g, b};
    endfunction

    logic        r_whl_valid;
    logic [23:0] r_whl_grb;
    logic [23:0] n_whl_grb;
    logic [23:0] s_rgb;
    logic        s_ser_ready;

    always_comb begin
        if (s_div_item.kind == KIND_RAINBOW[0]) begin
            s_rgb = wheel_rgb(s_div_item.quo[7:0] + s_div_item.aux[7:0]);
        end else begin
            s_rgb = s_div_item.aux;
        end
        n_whl_grb = {s_rgb[15:8], s_rgb[23:16], s_rgb[7:0]};
    end

    assign s_whl_ready = !r_whl_valid || s_ser_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_whl_valid <= 1'b0;
        end else if (s_whl_ready) begin
            r_whl_valid <= s_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_whl_ready) begin
            r_whl_grb <= n_whl_grb;
        end
    end

    rlrcg_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_whl_valid),
        .o_ready     (s_ser_ready),
        .i_grb       (r_whl_grb),
        .i_code_zero (r_code_zero),
        .i_code_one  (r_code_one),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> bench/rgb_led_rainbow_code_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_rainbow_code_generator_test
// Drives pixel requests (given colour and rainbow wheel) through the encoder
// under several register settings and random idling on both handshakes, and
// checks every SPI code byte against a local prediction of the pixel's colour.
// ----------------------------------------------------------------------------
import rlrcg_pkg::*;

class pixel_code_scoreboard;
    localparam int unsigned PIXELS_CAP = 1024;

    logic [10:0] pixel_count;
    logic [7:0]  code_zero;
    logic [7:0]  code_one;
    t_out_item   expected_codes[$];
    int          errors;

    function new();
        pixel_count = 11'd1;
        code_zero   = 8'd192;
        code_one    = 8'd248;
        errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PIXEL_COUNT: pixel_count = data;
            REG_CODE_ZERO:   code_zero   = data[7:0];
            REG_CODE_ONE:    code_one    = data[7:0];
            default: ;
        endcase
    endfunction

    function logic [23:0] wheel_rgb(logic [7:0] pos);
        logic [7:0] w;
        logic [7:0] v;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        w = 8'd255 - pos;
        if (w < 85) begin
            r = 8'(255 - 3 * w);
            g = 8'd0;
            b = 8'(3 * w);
        end else if (w < 170) begin
            v = w - 8'd85;
            r = 8'd0;
            g = 8'(3 * v);
            b = 8'(255 - 3 * v);
        end else begin
            v = w - 8'd170;
            r = 8'(3 * v);
            g = 8'(255 - 3 * v);
            b = 8'd0;
        end
        return {r, g, b};
    endfunction

    // queue the 24 code bytes that one accepted pixel request should produce
    function void note_pixel(t_in_item item);
        int unsigned divisor;
        int unsigned quotient;
        logic [7:0]  pos;
        logic [23:0] rgb;
        logic [23:0] grb;
        t_out_item   code;
        if (item.kind == 1'(KIND_COLOUR)) begin
            rgb = item.color_value;
        end else begin
            divisor = pixel_count;
            if (divisor == 0)
                divisor = 1;
            if (divisor > PIXELS_CAP)
                divisor = PIXELS_CAP;
            quotient = (int'(item.pixel_index) * 255) / divisor;
            pos = 8'(quotient + item.phase);
            rgb = wheel_rgb(pos);
        end
        grb = {rgb[15:8], rgb[23:16], rgb[7:0]};
        for (int k = 0; k < 24; k++) begin
            code.code_byte = grb[23-k] ? code_one : code_zero;
            code.last      = (k == 23);
            expected_codes.push_back(code);
        end
    endfunction

    function void check_byte(t_out_item got);
        t_out_item want;
        if (expected_codes.size() == 0) begin
            errors++;
            $error("code byte %02h with no pixel outstanding", got.code_byte);
            return;
        end
        want = expected_codes.pop_front();
        if (got.code_byte !== want.code_byte) begin
            errors++;
            $error("code_byte: expected %02h, got %02h", want.code_byte, got.code_byte);
        end
        if (got.last !== want.last) begin
            errors++;
            $error("last: expected %0b, got %0b", want.last, got.last);
        end
    endfunction
endclass

module rgb_led_rainbow_code_generator_test;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int IN_W = $bits(t_in_item);

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;

    logic gaps_on = 1'b1;
    logic stalls_on = 1'b1;
    int   cycle_count = 0;

    pixel_code_scoreboard sb = new();

    rgb_led_rainbow_code_generator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: occasional random stalls
    always @(posedge i_clk) begin
        out_ready <= !(stalls_on && $urandom_range(99) < 7);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && in_ready)
            sb.note_pixel(in_data);
        if (i_rst_n && out_valid && out_ready)
            sb.check_byte(out_data);
    end

    task automatic send_pixel(t_in_item item);
        if (gaps_on && $urandom_range(99) < 7) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic send_colour(logic [23:0] rgb);
        t_in_item item;
        item.kind        = 1'(KIND_COLOUR);
        item.color_value = rgb;
        item.pixel_index = 10'($urandom);
        item.phase       = 8'($urandom);
        send_pixel(item);
    endtask

    task automatic send_rainbow(logic [9:0] idx, logic [7:0] ph);
        t_in_item item;
        item.kind        = 1'(KIND_RAINBOW);
        item.color_value = 24'($urandom);
        item.pixel_index = idx;
        item.phase       = ph;
        send_pixel(item);
    endtask

    // hold off the sender until every outstanding byte is back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_codes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_registers(logic [10:0] count, logic [10:0] zero, logic [10:0] one);
        write_reg(REG_PIXEL_COUNT, count);
        write_reg(REG_CODE_ZERO, zero);
        write_reg(REG_CODE_ONE, one);
        write_reg(REG_SPARE, 11'($urandom));
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [10:0] count;
        t_in_item    item;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset register values, single-pixel chain
        send_colour(24'h000000);
        send_colour(24'hFFFFFF);
        send_colour(24'hAAAAAA);
        send_colour(24'h555555);
        send_colour(24'h12A4F0);
        send_rainbow(10'd0, 8'd0);
        send_rainbow(10'd1023, 8'd255);
        send_rainbow(10'd700, 8'd13);
        drain();

        // zero pixel count behaves as one; wheel segment boundaries
        set_registers(11'd0, 11'h700, 11'h0FF);
        send_rainbow(10'd0, 8'd0);
        send_rainbow(10'd0, 8'd85);
        send_rainbow(10'd0, 8'd86);
        send_rainbow(10'd0, 8'd170);
        send_rainbow(10'd0, 8'd171);
        send_rainbow(10'd0, 8'd255);
        send_rainbow(10'd1023, 8'd0);
        drain();

        // count above the chain limit is clamped
        set_registers(11'd2047, 11'h0FF, 11'h000);
        send_rainbow(10'd1023, 8'd1);
        send_rainbow(10'd512, 8'd128);
        send_colour(24'h00FF00);
        drain();

        set_registers(11'd1024, 11'h0A5, 11'h75A);
        send_rainbow(10'd1023, 8'd255);
        send_rainbow(10'd341, 8'd0);
        send_colour(24'hFF00FF);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case ($urandom_range(9))
                0:       count = 11'd0;
                1:       count = 11'($urandom_range(1025, 2047));
                2:       count = 11'd1;
                default: count = 11'($urandom_range(1, 1024));
            endcase
            set_registers(count, 11'($urandom), 11'($urandom));
            // second phase runs flat out on both sides
            gaps_on   = (ph != 1);
            stalls_on = (ph != 1);
            for (int n = 0; n < 28; n++) begin
                item = t_in_item'(IN_W'({$urandom, $urandom}));
                if ($urandom_range(3) != 0 && count != 0)
                    item.pixel_index = 10'($urandom_range(0, int'(count) - 1));
                send_pixel(item);
            end
            drain();
        end

        if (sb.errors == 0 && sb.expected_codes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
